### src/ladrc_pkg.sv
// Package for the first-order LADRC controller: widths, operation codes, states.
// Used by ladrc_mul, ladrc_div and first_order_ladrc_controller.
package ladrc_pkg;
	localparam int FracBitsDefault = 16;
	localparam int DtBits = 16;
	localparam int DataW = 32;

	typedef enum logic [1:0] {
		OP_UPDATE   = 2'd0,
		OP_FEEDBACK = 2'd1,
		OP_RESET    = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_PLANT_GAIN = 2'd0,
		CFG_OBS_BW     = 2'd1,
		CFG_CTRL_BW    = 2'd2,
		CFG_TRACK_RATE = 2'd3
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PREP,
		ST_B2_MUL,
		ST_B2_WAIT,
		ST_RDOT_MUL,
		ST_RDOT_WAIT,
		ST_X1_MUL,
		ST_X1_WAIT,
		ST_E1_MUL,
		ST_E1_WAIT,
		ST_E2_MUL,
		ST_E2_WAIT,
		ST_E3_MUL,
		ST_E3_WAIT,
		ST_Z1_MUL,
		ST_Z1_WAIT,
		ST_Z2_MUL,
		ST_Z2_WAIT,
		ST_WC_MUL,
		ST_WC_WAIT,
		ST_DIV,
		ST_DIV_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} unit_ctl_t;

	function automatic logic signed [DataW-1:0] sat32(input logic signed [DataW+1:0] v);
		logic signed [DataW+1:0] hi;
		logic signed [DataW+1:0] lo;
		hi = (DataW+2)'(33'sh0_7FFF_FFFF);
		lo = -hi - (DataW+2)'(1);
		if (v > hi) begin
			return hi[DataW-1:0];
		end else if (v < lo) begin
			return lo[DataW-1:0];
		end
		return v[DataW-1:0];
	endfunction
endpackage

### src/ladrc_mul.sv
// Bit-serial signed-by-unsigned multiplier: |a|*b >> shift, toward zero, saturated.
// Uses ladrc_pkg; a may also be taken as unsigned; one multiplier bit per cycle.
module ladrc_mul import ladrc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    a_unsigned,
	input  logic signed [DataW-1:0] a,
	input  logic [DataW-1:0]        b,
	input  logic [5:0]              shift,
	output logic                    done,
	output logic signed [DataW-1:0] result
);
	logic [DataW-1:0]   mag_q;
	logic [DataW-1:0]   mplr_q;
	logic [2*DataW-1:0] acc_q;
	logic [5:0]         cnt_q;
	logic               busy_q;
	logic               neg_q;
	logic               uns_q;
	logic [5:0]         sh_q;
	logic [2*DataW-1:0] shifted;
	logic [DataW:0]     clip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DataW-1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			uns_q <= a_unsigned;
			neg_q <= !a_unsigned && a[DataW-1];
			mag_q <= (!a_unsigned && a[DataW-1]) ? DataW'(-a) : DataW'(a);
			mplr_q <= b;
			acc_q <= '0;
			sh_q <= shift;
		end else if (busy_q) begin
			acc_q <= acc_q + (mplr_q[cnt_q[4:0]] ? ({{DataW{1'b0}}, mag_q} << cnt_q[4:0])
				: '0);
		end
	end

	always_comb begin
		shifted = acc_q >> sh_q;
		if (shifted > (2*DataW)'(33'h1_0000_0000)) begin
			clip = 33'h1_0000_0000;
		end else begin
			clip = shifted[DataW:0];
		end
		if (uns_q) begin
			result = (shifted > (2*DataW)'(33'h0_FFFF_FFFF)) ? '1 : shifted[DataW-1:0];
		end else if (neg_q) begin
			result = (clip > 33'h0_8000_0000) ? 32'sh8000_0000 : DataW'(-clip);
		end else begin
			result = (clip > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : clip[DataW-1:0];
		end
	end
endmodule

### src/ladrc_div.sv
// Restoring divider for the control output: (|num| << frac) / b0, one quotient bit a cycle.
// Uses ladrc_pkg; reports the signed 32-bit overflow as a fault.
module ladrc_div import ladrc_pkg::*; #(
	parameter int FracBits = FracBitsDefault
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DataW+1:0] num,
	input  logic [DataW-1:0]        den,
	output logic                    done,
	output logic signed [DataW-1:0] quot,
	output logic                    fault
);
	localparam int NW = DataW + 2 + FracBits;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0]  dvd_q;
	logic [DataW:0] rem_q;
	logic [NW-1:0]  q_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           neg_q;
	logic [DataW-1:0] den_q;
	logic [DataW+1:0] trial;
	logic [DataW+1:0] nmag;

	assign nmag = num[DataW+1] ? (DataW+2)'(-num) : (DataW+2)'(num);
	assign trial = {rem_q, dvd_q[NW-1]} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NW-1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[DataW+1];
			dvd_q <= {nmag, {FracBits{1'b0}}};
			den_q <= den;
			rem_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (!trial[DataW+1]) begin
				rem_q <= trial[DataW:0];
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DataW-1:0], dvd_q[NW-1]};
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (neg_q) begin
			fault = q_q > NW'(33'h0_8000_0000);
		end else begin
			fault = q_q > NW'(33'h0_7FFF_FFFF);
		end
		quot = fault ? '0 : (neg_q ? DataW'(-q_q) : q_q[DataW-1:0]);
	end
endmodule

### src/first_order_ladrc_controller.sv
// First-order LADRC controller top level with serial multiplier and divider.
// An update word runs nine multiplies, a division and the setup and output steps, one at
// a time; with the observer held five multiplies are skipped.
// A new word is taken once the result is loaded and the controller is idle again;
// feedback and reset words are taken in idle and do not leave it.
// The output register lets the next word enter while a result waits.
// arst_n sets the configuration to its reset values and clears all estimator state.
module first_order_ladrc_controller import ladrc_pkg::*; #(
	parameter int FracBits = FracBitsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// operation[1:0], measurement[33:2], reference[65:34], time_step[81:66],
	// applied_control[113:82], zero fill to 120 bits
	input  logic [119:0] s_tdata,
	// landed[0], measurement_bad[1]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// control[31:0]
	output logic [31:0]  m_tdata,
	// fault_reset[0]
	output logic         m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	localparam logic [DataW-1:0] OneQ = DataW'(64'd1 << FracBits);
	localparam logic [DataW-1:0] FloorHundredth = DataW'((64'd1 << FracBits) + 50) / 100;
	localparam logic [DataW-1:0] FloorTenth = DataW'((64'd1 << FracBits) + 5) / 10;
	localparam logic signed [DataW-1:0] LimitFive = DataW'(5 * (64'd1 << FracBits));

	state_t state_q, state_d;
	logic [DataW-1:0] b0_q, wo_q, wc_q, lam_q;
	logic started_q, snap_q;
	logic signed [DataW-1:0] x1_q, z1_q, z2_q, prev_q;
	logic signed [DataW-1:0] y_q, r_q, rdot_q, e_q, d_q, t_q;
	logic signed [DataW+1:0] acc_q;
	logic [DtBits-1:0] dt_q;
	logic hold_q;
	logic [DataW-1:0] beta1_q, beta2_q;
	logic signed [DataW-1:0] ctrl_q;
	logic fault_q, out_valid_q;
	logic out_load;

	logic mul_start;
	logic mul_uns;
	logic signed [DataW-1:0] mul_a;
	logic [DataW-1:0] mul_b;
	logic [5:0] mul_sh;
	logic mul_done;
	logic signed [DataW-1:0] mul_r;
	logic div_start, div_done, div_fault;
	logic signed [DataW-1:0] div_q;
	logic signed [DataW+1:0] num_q;
	unit_ctl_t ctl;

	logic in_acc;
	op_t op_in;
	logic signed [DataW-1:0] y_in, r_in, ac_in;
	logic [DataW-1:0] b0f, wof, wcf;

	assign op_in = op_t'(s_tdata[1:0]);
	assign y_in = s_tdata[33:2];
	assign r_in = s_tdata[65:34];
	assign ac_in = s_tdata[113:82];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_tready);
	assign cfg_ready = 1'b1;
	assign b0f = (b0_q < FloorHundredth) ? FloorHundredth : b0_q;
	assign wof = (wo_q < FloorTenth) ? FloorTenth : wo_q;
	assign wcf = (wc_q < FloorHundredth) ? FloorHundredth : wc_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata = ctrl_q;
	assign m_tuser = fault_q;

	ladrc_mul u_mul (
		.clk, .arst_n, .start(mul_start), .a_unsigned(mul_uns), .a(mul_a), .b(mul_b),
		.shift(mul_sh), .done(mul_done), .result(mul_r)
	);

	ladrc_div #(.FracBits(FracBits)) u_div (
		.clk, .arst_n, .start(div_start), .num(num_q), .den(b0f),
		.done(div_done), .quot(div_q), .fault(div_fault)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc && op_in == OP_UPDATE) state_d = ST_PREP;
			ST_PREP: state_d = ST_B2_MUL;
			ST_B2_MUL: state_d = ST_B2_WAIT;
			ST_B2_WAIT: if (mul_done) state_d = ST_RDOT_MUL;
			ST_RDOT_MUL: state_d = ST_RDOT_WAIT;
			ST_RDOT_WAIT: if (mul_done) state_d = ST_X1_MUL;
			ST_X1_MUL: state_d = ST_X1_WAIT;
			ST_X1_WAIT: if (mul_done) state_d = hold_q ? ST_WC_MUL : ST_E1_MUL;
			ST_E1_MUL: state_d = ST_E1_WAIT;
			ST_E1_WAIT: if (mul_done) state_d = ST_E2_MUL;
			ST_E2_MUL: state_d = ST_E2_WAIT;
			ST_E2_WAIT: if (mul_done) state_d = ST_E3_MUL;
			ST_E3_MUL: state_d = ST_E3_WAIT;
			ST_E3_WAIT: if (mul_done) state_d = ST_Z1_MUL;
			ST_Z1_MUL: state_d = ST_Z1_WAIT;
			ST_Z1_WAIT: if (mul_done) state_d = ST_Z2_MUL;
			ST_Z2_MUL: state_d = ST_Z2_WAIT;
			ST_Z2_WAIT: if (mul_done) state_d = ST_WC_MUL;
			ST_WC_MUL: state_d = ST_WC_WAIT;
			ST_WC_WAIT: if (mul_done) state_d = ST_DIV;
			ST_DIV: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_done) state_d = ST_OUT;
			ST_OUT: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		mul_uns = 1'b0;
		mul_a = '0;
		mul_b = '0;
		mul_sh = 6'(FracBits);
		unique case (state_q)
			ST_B2_MUL: begin
				ctl.start = 1'b1;
				mul_uns = 1'b1;
				mul_a = wof;
				mul_b = wof;
			end
			ST_RDOT_MUL: begin
				ctl.start = 1'b1;
				mul_a = sat32((DataW+2)'(r_q) - (DataW+2)'(x1_q));
				mul_b = lam_q;
			end
			ST_X1_MUL: begin
				ctl.start = 1'b1;
				mul_a = rdot_q;
				mul_b = DataW'(dt_q);
				mul_sh = 6'(DtBits);
			end
			ST_E1_MUL: begin
				ctl.start = 1'b1;
				mul_a = e_q;
				mul_b = beta1_q;
			end
			ST_E2_MUL: begin
				ctl.start = 1'b1;
				mul_a = prev_q;
				mul_b = b0f;
			end
			ST_E3_MUL: begin
				ctl.start = 1'b1;
				mul_a = e_q;
				mul_b = beta2_q;
			end
			ST_Z1_MUL: begin
				ctl.start = 1'b1;
				mul_a = d_q;
				mul_b = DataW'(dt_q);
				mul_sh = 6'(DtBits);
			end
			ST_Z2_MUL: begin
				ctl.start = 1'b1;
				mul_a = t_q;
				mul_b = DataW'(dt_q);
				mul_sh = 6'(DtBits);
			end
			ST_WC_MUL: begin
				ctl.start = 1'b1;
				mul_a = sat32((DataW+2)'(x1_q) - (DataW+2)'(z1_q));
				mul_b = wcf;
			end
			ST_DIV: ctl.done = 1'b1;
			default: ctl.busy = (state_q != ST_IDLE);
		endcase
		mul_start = ctl.start;
		div_start = ctl.done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			b0_q <= OneQ;
			wo_q <= DataW'(10 * (64'd1 << FracBits));
			wc_q <= DataW'(5 * (64'd1 << FracBits));
			lam_q <= DataW'(20 * (64'd1 << FracBits));
			started_q <= 1'b0;
			snap_q <= 1'b0;
			x1_q <= '0;
			z1_q <= '0;
			z2_q <= '0;
			prev_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_PLANT_GAIN: b0_q <= cfg_data;
					CFG_OBS_BW: wo_q <= cfg_data;
					CFG_CTRL_BW: wc_q <= cfg_data;
					CFG_TRACK_RATE: lam_q <= cfg_data;
					default: b0_q <= b0_q;
				endcase
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (in_acc) begin
				unique case (op_in)
					OP_FEEDBACK: begin
						if (ac_in > LimitFive) prev_q <= LimitFive;
						else if (ac_in < -LimitFive) prev_q <= -LimitFive;
						else prev_q <= ac_in;
					end
					OP_RESET: begin
						started_q <= 1'b0;
						snap_q <= 1'b1;
						z2_q <= '0;
						prev_q <= '0;
					end
					OP_UPDATE: begin
						if (!started_q || snap_q) x1_q <= r_in;
						if (!started_q) z1_q <= y_in;
						started_q <= 1'b1;
						snap_q <= 1'b0;
					end
					default: started_q <= started_q;
				endcase
			end
			unique case (state_q)
				ST_PREP: if (hold_q) begin
					z1_q <= y_q;
					z2_q <= '0;
				end
				ST_X1_WAIT: if (mul_done) begin
					x1_q <= sat32((DataW+2)'(x1_q) + (DataW+2)'(mul_r));
				end
				ST_Z1_WAIT: if (mul_done) begin
					z1_q <= sat32((DataW+2)'(z1_q) + (DataW+2)'(mul_r));
				end
				ST_Z2_WAIT: if (mul_done) begin
					z2_q <= sat32((DataW+2)'(z2_q) + (DataW+2)'(mul_r));
				end
				ST_DIV_WAIT: if (div_done) begin
					prev_q <= div_q;
					if (div_fault) begin
						z1_q <= y_q;
						z2_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			y_q <= y_in;
			r_q <= r_in;
			dt_q <= s_tdata[81:66];
			hold_q <= s_tuser[0] | s_tuser[1];
		end
		if (out_load) begin
			ctrl_q <= div_q;
			fault_q <= div_fault;
		end
		unique case (state_q)
			ST_PREP: begin
				beta1_q <= wof[DataW-1] ? '1 : {wof[DataW-2:0], 1'b0};
				e_q <= sat32((DataW+2)'(z1_q) - (DataW+2)'(y_q));
			end
			ST_B2_WAIT: if (mul_done) beta2_q <= mul_r;
			ST_RDOT_WAIT: if (mul_done) rdot_q <= mul_r;
			ST_E1_WAIT: if (mul_done) acc_q <= (DataW+2)'(z2_q) - (DataW+2)'(mul_r);
			ST_E2_WAIT: if (mul_done) d_q <= sat32(acc_q + (DataW+2)'(mul_r));
			ST_E3_WAIT: if (mul_done) t_q <= sat32(-(DataW+2)'(mul_r));
			ST_WC_WAIT: if (mul_done) begin
				num_q <= (DataW+2)'(mul_r) + (DataW+2)'(rdot_q) - (DataW+2)'(z2_q);
			end
			default: acc_q <= acc_q;
		endcase
	end

`ifndef SYNTH
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result word dropped");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_tready) else $error("word accepted while busy");
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0) else $error("fault with nonzero control");
`endif
endmodule
